// File: hdl/det4_pkg.sv
// Package for the 4x4 integer determinant pipeline: word and row types,
// pipeline control struct, cofactor index tables and the wrapping multiply.
// No dependencies.
package det4_pkg;

  localparam int NUM_STAGES = 6;
  localparam int NUM_PAIRS  = 6;

  typedef logic [31:0] word_t;
  // Element j of a row sits at bits 32*j+31 .. 32*j
  typedef logic [3:0][31:0] row_t;
  typedef logic [NUM_PAIRS-1:0][31:0] pair_vec_t;

  // Per-stage capture enables from the pipeline controller
  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
  } pipe_ctrl_t;

  // Column pairs of the lower two rows, in minor index order
  localparam logic [1:0] PAIR_I [NUM_PAIRS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] PAIR_J [NUM_PAIRS] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

  // For the cofactor of column j: which row-1 column weights which 2x2 minor
  localparam logic [1:0] M3_COL [4][3] = '{
    '{2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd2, 2'd3},
    '{2'd0, 2'd1, 2'd3},
    '{2'd0, 2'd1, 2'd2}
  };
  localparam logic [2:0] M3_PAIR [4][3] = '{
    '{3'd5, 3'd4, 3'd3},
    '{3'd5, 3'd2, 3'd1},
    '{3'd4, 3'd2, 3'd0},
    '{3'd3, 3'd1, 3'd0}
  };

  // Low half of a 32x32 product
  function automatic word_t mul_lo(input word_t a, input word_t b);
    return a * b;
  endfunction

endpackage

// File: hdl/int_matrix4_determinant.sv
// 4x4 signed integer determinant, wrapped modulo 2^32, as a 6-stage pipeline.
// Throughput: one matrix per cycle unless out_tready stalls the output; each
// stage holds one matrix, and an empty stage fills even while the output
// register waits on out_tready.
// Reset clears the valid bits only; data registers are not reset.
// Depends on det4_pkg, det4_pipe_ctrl, det4_minor2, det4_minor3, det4_expand.
module int_matrix4_determinant
  import det4_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [63:0] row0_cols01, [127:64] row0_cols23, [191:128] row1_cols01,
  // [255:192] row1_cols23, [319:256] row2_cols01, [383:320] row2_cols23,
  // [447:384] row3_cols01, [511:448] row3_cols23
  input  logic [511:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] determinant
  output logic [31:0]  out_tdata
);

  pipe_ctrl_t ctrl;
  row_t       row_a, row_b, row_c, row_d;
  pair_vec_t  minor;
  row_t       a_s2, b_s2, cof, a_s4;
  word_t      det;

  // Unpack rows; lower column sits in the low half of each field
  assign row_a = in_tdata[127:0];
  assign row_b = in_tdata[255:128];
  assign row_c = in_tdata[383:256];
  assign row_d = in_tdata[511:384];

  det4_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .ctrl      (ctrl)
  );

  det4_minor2 u_minor2 (
    .clk     (clk),
    .ctrl    (ctrl),
    .row_a   (row_a),
    .row_b   (row_b),
    .row_c   (row_c),
    .row_d   (row_d),
    .minor   (minor),
    .row_a_o (a_s2),
    .row_b_o (b_s2)
  );

  det4_minor3 u_minor3 (
    .clk     (clk),
    .ctrl    (ctrl),
    .minor   (minor),
    .row_a   (a_s2),
    .row_b   (b_s2),
    .cof     (cof),
    .row_a_o (a_s4)
  );

  det4_expand u_expand (
    .clk   (clk),
    .ctrl  (ctrl),
    .cof   (cof),
    .row_a (a_s4),
    .det   (det)
  );

  assign out_tdata = det;

endmodule

// File: hdl/det4_pipe_ctrl.sv
// Valid bits and stall handling for the six determinant stages.
// Depends on det4_pkg.
module det4_pipe_ctrl
  import det4_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output pipe_ctrl_t ctrl
);

  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] valid_nxt;
  logic [NUM_STAGES-1:0] free;
  logic [NUM_STAGES-1:0] upstream;

  // A stage may load when it is empty or its content moves on
  always_comb begin
    free[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      free[k] = !valid_r[k] || free[k+1];
    end
  end

  // Advance valid bits; bubbles collapse behind a stalled stage
  always_comb begin
    upstream = {valid_r[NUM_STAGES-2:0], in_valid};
    for (int k = 0; k < NUM_STAGES; k++) begin
      valid_nxt[k] = free[k] ? upstream[k] : valid_r[k];
      ctrl.en[k]   = free[k] && upstream[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready  = free[0];
  assign out_valid = valid_r[NUM_STAGES-1];

endmodule

// File: hdl/det4_minor2.sv
// Stages 1-2: the six 2x2 minors of the two lower rows.
// Depends on det4_pkg.
module det4_minor2
  import det4_pkg::*;
(
  input  logic       clk,
  input  pipe_ctrl_t ctrl,
  input  row_t       row_a,
  input  row_t       row_b,
  input  row_t       row_c,
  input  row_t       row_d,
  output pair_vec_t  minor,
  output row_t       row_a_o,
  output row_t       row_b_o
);

  pair_vec_t prod_p_r, prod_q_r, minor_r;
  row_t      a1_r, b1_r, a2_r, b2_r;

  // Stage 1: cross products c[i]*d[j] and c[j]*d[i]
  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      for (int p = 0; p < NUM_PAIRS; p++) begin
        prod_p_r[p] <= mul_lo(row_c[PAIR_I[p]], row_d[PAIR_J[p]]);
        prod_q_r[p] <= mul_lo(row_c[PAIR_J[p]], row_d[PAIR_I[p]]);
      end
      a1_r <= row_a;
      b1_r <= row_b;
    end
  end

  // Stage 2: differences
  always_ff @(posedge clk) begin
    if (ctrl.en[1]) begin
      for (int p = 0; p < NUM_PAIRS; p++) begin
        minor_r[p] <= prod_p_r[p] - prod_q_r[p];
      end
      a2_r <= a1_r;
      b2_r <= b1_r;
    end
  end

  assign minor   = minor_r;
  assign row_a_o = a2_r;
  assign row_b_o = b2_r;

endmodule

// File: hdl/det4_minor3.sv
// Stages 3-4: the four 3x3 minors of rows 1..3, weighted by row 1.
// Depends on det4_pkg.
module det4_minor3
  import det4_pkg::*;
(
  input  logic       clk,
  input  pipe_ctrl_t ctrl,
  input  pair_vec_t  minor,
  input  row_t       row_a,
  input  row_t       row_b,
  output row_t       cof,
  output row_t       row_a_o
);

  logic [3:0][2:0][31:0] term_r;
  row_t                  cof_r, a3_r, a4_r;

  // Stage 3: row-1 element times 2x2 minor
  always_ff @(posedge clk) begin
    if (ctrl.en[2]) begin
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 3; k++) begin
          term_r[j][k] <= mul_lo(row_b[M3_COL[j][k]], minor[M3_PAIR[j][k]]);
        end
      end
      a3_r <= row_a;
    end
  end

  // Stage 4: alternate signs
  always_ff @(posedge clk) begin
    if (ctrl.en[3]) begin
      for (int j = 0; j < 4; j++) begin
        cof_r[j] <= term_r[j][0] - term_r[j][1] + term_r[j][2];
      end
      a4_r <= a3_r;
    end
  end

  assign cof     = cof_r;
  assign row_a_o = a4_r;

endmodule

// File: hdl/det4_expand.sv
// Stages 5-6: expansion along the first row into the determinant.
// Depends on det4_pkg.
module det4_expand
  import det4_pkg::*;
(
  input  logic       clk,
  input  pipe_ctrl_t ctrl,
  input  row_t       cof,
  input  row_t       row_a,
  output word_t      det
);

  row_t  prod_r;
  word_t det_r;

  // Stage 5: first-row element times its 3x3 minor
  always_ff @(posedge clk) begin
    if (ctrl.en[4]) begin
      for (int j = 0; j < 4; j++) begin
        prod_r[j] <= mul_lo(row_a[j], cof[j]);
      end
    end
  end

  // Stage 6: signed sum, held as the output register
  always_ff @(posedge clk) begin
    if (ctrl.en[5]) begin
      det_r <= prod_r[0] - prod_r[1] + prod_r[2] - prod_r[3];
    end
  end

  assign det = det_r;

endmodule

// File: hdl/det4_checker.sv
// Port-level checks for the determinant pipeline, bound to the top level.
// Depends on int_matrix4_determinant's ports only.
module det4_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [31:0]  out_tdata
);

  // Output is empty in the cycle after reset
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid set after reset");

  // Empty output register means the pipe has room for a request
  assert property (@(posedge clk) disable iff (!rst_n) !out_tvalid |-> in_tready)
    else $error("input stalled while output empty");

  // A draining output lets the whole pipe advance
  assert property (@(posedge clk) disable iff (!rst_n) out_tready |-> in_tready)
    else $error("input stalled while output drains");

  // Stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind int_matrix4_determinant det4_checker u_det4_checker (.*);
